FILE: src/cpa_pkg.sv
// ----------------------------------------------------------------------------
// cpa_pkg
// Shared types, constants and helpers for the camera pixel to ARGB32 converter.
// ----------------------------------------------------------------------------
package cpa_pkg;

  typedef enum logic [1:0] {
    FMT_RGB24  = 2'd0,
    FMT_YUYV   = 2'd1,
    FMT_RGB565 = 2'd2,
    FMT_RGB444 = 2'd3
  } fmt_e;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  // BT.601 coefficients, 8 fractional bits
  localparam logic signed [17:0] COEF_Y   = 18'sd298;
  localparam logic signed [17:0] COEF_RV  = 18'sd409;
  localparam logic signed [17:0] COEF_GU  = 18'sd100;
  localparam logic signed [17:0] COEF_GV  = 18'sd208;
  localparam logic signed [17:0] COEF_BU  = 18'sd516;
  localparam logic signed [17:0] Y_ROUND  = 18'sd128;
  localparam logic signed [9:0]  Y_OFFSET = 10'sd16;
  localparam logic signed [8:0]  UV_MID   = 9'sd128;

  // Pixel pair handed to the output stage
  typedef struct packed {
    logic [31:0] pix0;
    logic [31:0] pix1;
    logic        two;
    logic        flast;
  } pair_t;

  // Clamp a scaled channel sum to 0..255 after dropping 8 fraction bits
  function automatic logic [7:0] clamp8(input logic signed [19:0] s);
    logic [7:0] r;
    if (s[19]) begin
      r = 8'd0;
    end else if (|s[18:16]) begin
      r = 8'hFF;
    end else begin
      r = s[15:8];
    end
    return r;
  endfunction

endpackage

FILE: src/cpa_out_stage.sv
// ----------------------------------------------------------------------------
// cpa_out_stage
// Output register that holds one pixel pair and sends it one pixel per beat.
// ----------------------------------------------------------------------------
module cpa_out_stage import cpa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        pair_valid_i,
  input  pair_t       pair_i,
  output logic        take_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] argb_pixel_o,
  output logic        last_of_item_o,
  output logic        frame_end_o
);

  logic  valid_q;
  logic  sel_q;
  pair_t pair_q;
  logic  last_beat;

  assign last_beat = !pair_q.two || sel_q;
  // Free the register when empty or when its final pixel leaves
  assign take_o    = !valid_q || (out_ready_i && last_beat);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else if (take_o) begin
      valid_q <= pair_valid_i;
      sel_q   <= 1'b0;
    end else if (out_ready_i) begin
      sel_q   <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && pair_valid_i) begin
      pair_q <= pair_i;
    end
  end

  assign out_valid_o    = valid_q;
  assign argb_pixel_o   = sel_q ? pair_q.pix1 : pair_q.pix0;
  assign last_of_item_o = last_beat;
  assign frame_end_o    = last_beat && pair_q.flast;

endmodule

FILE: src/camera_pixel_to_argb32.sv
// ----------------------------------------------------------------------------
// camera_pixel_to_argb32
// Converts camera source byte groups to opaque ARGB32 pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one source group per
//   transaction: four bytes and a frame-last flag. Output channel
//   (out_valid_o/out_ready_i) carries one ARGB32 pixel per transaction with
//   last_of_item_o on the final pixel of a group and frame_end_o on the
//   final pixel of a frame.
//   source_format_i is written when source_format_we_i is high; change it
//   only while no group is in flight.
//   The first pixel of a group is offered once the group has passed the
//   multiply stage, the add stage and the clamp/output register.
//   Throughput: RGB24, RGB565 and RGB444 take one group per cycle while
//   out_ready_i stays high; a YUYV group yields two pixels, so YUYV groups
//   are held back by the single-pixel output port.
//   Reset clears all valid bits and sets the format to RGB24.
//   When the receiver stalls, the pipeline stages hold their contents and
//   in_ready_o drops once every stage is full; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module camera_pixel_to_argb32 import cpa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        source_format_we_i,
  input  logic [1:0]  source_format_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  src_byte0_i,
  input  logic [7:0]  src_byte1_i,
  input  logic [7:0]  src_byte2_i,
  input  logic [7:0]  src_byte3_i,
  input  logic        frame_last_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] argb_pixel_o,
  output logic        last_of_item_o,
  output logic        frame_end_o
);

  // Configuration register
  fmt_e fmt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_RGB24;
    end else if (source_format_we_i) begin
      fmt_q <= fmt_e'(source_format_i);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: direct RGB unpacking and the BT.601 products
  // --------------------------------------------------------------------------
  logic              is_yuv_d;
  logic [23:0]       rgb_d;
  logic signed [9:0] y0m, y1m;
  logic signed [8:0] dm, em;
  logic signed [17:0] c0_d, c1_d, rv_d, guv_d, bu_d;

  assign is_yuv_d = (fmt_q == FMT_YUYV);

  always_comb begin
    case (fmt_q)
      FMT_RGB565: begin
        rgb_d = {src_byte1_i & 8'hF8,
                 src_byte1_i[2:0], src_byte0_i[7:5], 2'b00,
                 src_byte0_i[4:0], 3'b000};
      end
      FMT_RGB444: begin
        rgb_d = {src_byte1_i[3:0], 4'h0,
                 src_byte0_i[7:4], 4'h0,
                 src_byte0_i[3:0], 4'h0};
      end
      default: begin
        rgb_d = {src_byte0_i, src_byte1_i, src_byte2_i};
      end
    endcase
  end

  assign y0m   = $signed({2'b00, src_byte0_i}) - Y_OFFSET;
  assign y1m   = $signed({2'b00, src_byte2_i}) - Y_OFFSET;
  assign dm    = $signed({1'b0, src_byte1_i}) - UV_MID;
  assign em    = $signed({1'b0, src_byte3_i}) - UV_MID;
  assign c0_d  = 18'(y0m) * COEF_Y + Y_ROUND;
  assign c1_d  = 18'(y1m) * COEF_Y + Y_ROUND;
  assign rv_d  = 18'(em) * COEF_RV;
  assign guv_d = 18'(dm) * COEF_GU + 18'(em) * COEF_GV;
  assign bu_d  = 18'(dm) * COEF_BU;

  logic               s1_valid_q;
  logic               s1_yuv_q, s1_flast_q;
  logic [23:0]        s1_rgb_q;
  logic signed [17:0] s1_c0_q, s1_c1_q, s1_rv_q, s1_guv_q, s1_bu_q;

  // --------------------------------------------------------------------------
  // Stage 2: channel sums for both pixels
  // --------------------------------------------------------------------------
  logic               s2_valid_q;
  logic               s2_yuv_q, s2_flast_q;
  logic [23:0]        s2_rgb_q;
  logic signed [19:0] s2_r0_q, s2_g0_q, s2_b0_q, s2_r1_q, s2_g1_q, s2_b1_q;

  logic s1_en, s2_en, take;

  // Advance a stage when it is empty or the stage after it advances
  assign s2_en      = !s2_valid_q || take;
  assign s1_en      = !s1_valid_q || s2_en;
  assign in_ready_o = s1_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_en) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en && in_valid_i) begin
      s1_yuv_q   <= is_yuv_d;
      s1_flast_q <= frame_last_in_i;
      s1_rgb_q   <= rgb_d;
      s1_c0_q    <= c0_d;
      s1_c1_q    <= c1_d;
      s1_rv_q    <= rv_d;
      s1_guv_q   <= guv_d;
      s1_bu_q    <= bu_d;
    end
    if (s2_en && s1_valid_q) begin
      s2_yuv_q   <= s1_yuv_q;
      s2_flast_q <= s1_flast_q;
      s2_rgb_q   <= s1_rgb_q;
      s2_r0_q    <= 20'(s1_c0_q) + 20'(s1_rv_q);
      s2_g0_q    <= 20'(s1_c0_q) - 20'(s1_guv_q);
      s2_b0_q    <= 20'(s1_c0_q) + 20'(s1_bu_q);
      s2_r1_q    <= 20'(s1_c1_q) + 20'(s1_rv_q);
      s2_g1_q    <= 20'(s1_c1_q) - 20'(s1_guv_q);
      s2_b1_q    <= 20'(s1_c1_q) + 20'(s1_bu_q);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: clamp, pack and hand the pair to the output register
  // --------------------------------------------------------------------------
  pair_t pair;

  always_comb begin
    pair.two   = s2_yuv_q;
    pair.flast = s2_flast_q;
    pair.pix1  = {ALPHA_OPAQUE, clamp8(s2_r1_q), clamp8(s2_g1_q), clamp8(s2_b1_q)};
    if (s2_yuv_q) begin
      pair.pix0 = {ALPHA_OPAQUE, clamp8(s2_r0_q), clamp8(s2_g0_q), clamp8(s2_b0_q)};
    end else begin
      pair.pix0 = {ALPHA_OPAQUE, s2_rgb_q};
    end
  end

  cpa_out_stage u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pair_valid_i   (s2_valid_q),
    .pair_i         (pair),
    .take_o         (take),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .argb_pixel_o   (argb_pixel_o),
    .last_of_item_o (last_of_item_o),
    .frame_end_o    (frame_end_o)
  );

endmodule

FILE: src/cpa_checker.sv
// ----------------------------------------------------------------------------
// cpa_checker
// Port-level checks on the converter's output channel.
// ----------------------------------------------------------------------------
module cpa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] argb_pixel_o,
  input logic        last_of_item_o,
  input logic        frame_end_o
);

  // Hold a stalled transaction
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(argb_pixel_o))
    else $error("stalled output transaction dropped or changed");

  a_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> argb_pixel_o[31:24] == 8'hFF)
    else $error("pixel not opaque");

  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> last_of_item_o)
    else $error("frame end on a pixel that does not close its group");

  // The second pixel of a pair follows at once
  a_pair_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_of_item_o |=> out_valid_o && last_of_item_o)
    else $error("second pixel of a pair not presented next cycle");

endmodule

bind camera_pixel_to_argb32 cpa_checker u_cpa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .argb_pixel_o   (argb_pixel_o),
  .last_of_item_o (last_of_item_o),
  .frame_end_o    (frame_end_o)
);

FILE: test/tb_camera_pixel_to_argb32.sv
// ----------------------------------------------------------------------------
// tb_camera_pixel_to_argb32
// Self-checking bench for the camera pixel to ARGB32 converter. It predicts
// every pixel from the accepted source groups under the current source format
// and compares field by field against the output stream. Directed corner
// groups run for each format first, then random groups across several formats,
// with random idle cycles on both sides.
// ----------------------------------------------------------------------------
module tb_camera_pixel_to_argb32;
  timeunit 1ns;
  timeprecision 1ps;

  import cpa_pkg::*;

  // One predicted output transaction
  typedef struct {
    logic [31:0] pix;
    logic        item_last;
    logic        fend;
  } pixel_t;

  // Pixel predictor and store of expected pixels, in acceptance order
  class argb_scoreboard;
    fmt_e   fmt;
    pixel_t expected_q[$];
    int     mismatches;

    function new();
      fmt        = FMT_RGB24;
      mismatches = 0;
    endfunction

    function void apply_format(fmt_e f);
      fmt = f;
    endfunction

    // Drop 8 fraction bits, saturate to 0..255
    function logic [7:0] clamp_chan(int s);
      int q;
      if (s < 0) begin
        return 8'd0;
      end
      q = s / 256;
      if (q > 255) begin
        return 8'hFF;
      end
      return q[7:0];
    endfunction

    function logic [31:0] yuv_to_argb(logic [7:0] y, logic [7:0] u, logic [7:0] v);
      int c;
      int d;
      int e;
      c = (int'(y) - 16) * 298 + 128;
      d = int'(u) - 128;
      e = int'(v) - 128;
      return {ALPHA_OPAQUE, clamp_chan(c + 409 * e),
              clamp_chan(c - 100 * d - 208 * e), clamp_chan(c + 516 * d)};
    endfunction

    // Queue the pixels that one accepted source group must produce
    function void note_group(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                             logic [7:0] b3, logic flast);
      pixel_t p;
      p.item_last = 1'b1;
      p.fend      = flast;
      case (fmt)
        FMT_YUYV: begin
          pixel_t first;
          first.pix       = yuv_to_argb(b0, b1, b3);
          first.item_last = 1'b0;
          first.fend      = 1'b0;
          expected_q.push_back(first);
          p.pix = yuv_to_argb(b2, b1, b3);
        end
        FMT_RGB565: p.pix = {ALPHA_OPAQUE, b1[7:3], 3'b000,
                             b1[2:0], b0[7:5], 2'b00, b0[4:0], 3'b000};
        FMT_RGB444: p.pix = {ALPHA_OPAQUE, b1[3:0], 4'h0, b0[7:4], 4'h0,
                             b0[3:0], 4'h0};
        default:    p.pix = {ALPHA_OPAQUE, b0, b1, b2};
      endcase
      expected_q.push_back(p);
    endfunction

    task report(string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      mismatches++;
    endtask

    task check_pixel(logic [31:0] pix, logic item_last, logic fend);
      pixel_t p;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected pixel %08h", pix));
        return;
      end
      p = expected_q.pop_front();
      if (pix !== p.pix) begin
        report($sformatf("argb_pixel %08h, want %08h", pix, p.pix));
      end
      if (item_last !== p.item_last) begin
        report($sformatf("last_of_item %b, want %b", item_last, p.item_last));
      end
      if (fend !== p.fend) begin
        report($sformatf("frame_end %b, want %b", fend, p.fend));
      end
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni             = 1'b0;
  logic        source_format_we_i = 1'b0;
  logic [1:0]  source_format_i    = FMT_RGB24;
  logic        in_valid_i         = 1'b0;
  logic        in_ready_o;
  logic [7:0]  src_byte0_i        = 8'h00;
  logic [7:0]  src_byte1_i        = 8'h00;
  logic [7:0]  src_byte2_i        = 8'h00;
  logic [7:0]  src_byte3_i        = 8'h00;
  logic        frame_last_in_i    = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i        = 1'b0;
  logic [31:0] argb_pixel_o;
  logic        last_of_item_o;
  logic        frame_end_o;

  // Set while neither side may idle
  bit calm = 1'b0;

  argb_scoreboard sb;

  camera_pixel_to_argb32 DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .source_format_we_i (source_format_we_i),
    .source_format_i    (source_format_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .src_byte0_i        (src_byte0_i),
    .src_byte1_i        (src_byte1_i),
    .src_byte2_i        (src_byte2_i),
    .src_byte3_i        (src_byte3_i),
    .frame_last_in_i    (frame_last_in_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .argb_pixel_o       (argb_pixel_o),
    .last_of_item_o     (last_of_item_o),
    .frame_end_o        (frame_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the pipeline hangs; the slowest correct run is far shorter
  initial begin
    #1_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Output side: check each pixel transaction, then pick the next ready.
  // Values read right after the edge are the ones the DUT sampled.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        sb.check_pixel(argb_pixel_o, last_of_item_o, frame_end_o);
      end
      out_ready_i <= calm || ($urandom_range(99) >= 19);
    end
  end

  // Offer one source group and hold it until the DUT takes it. An optional
  // random gap comes first so idles fall on every phase of the YUYV pair.
  task send_group(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
                  input logic [7:0] b3, input logic flast);
    int gap;
    gap = 0;
    while (!calm && $urandom_range(99) < 19) begin
      gap++;
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    src_byte0_i     <= b0;
    src_byte1_i     <= b1;
    src_byte2_i     <= b2;
    src_byte3_i     <= b3;
    frame_last_in_i <= flast;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_group(b0, b1, b2, b3, flast);
  endtask

  // Drop valid and hold off until every expected pixel has come out
  task drain();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  // Change format only with the pipeline empty; drain first, then idle
  // before the write
  task write_format(input fmt_e f);
    drain();
    repeat (4) @(posedge clk_i);
    source_format_we_i <= 1'b1;
    source_format_i    <= f;
    @(posedge clk_i);
    source_format_we_i <= 1'b0;
    sb.apply_format(f);
  endtask

  // Lean toward the values where the conversion saturates or crosses offsets
  function logic [7:0] pick_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'd16;
      3:       return 8'd128;
      4:       return 8'd235;
      default: return 8'($urandom);
    endcase
  endfunction

  task run_random(input int n);
    for (int i = 0; i < n; i++) begin
      send_group(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                 $urandom_range(7) == 0);
    end
  endtask

  fmt_e phase_fmt [8] = '{FMT_RGB444, FMT_YUYV, FMT_RGB565, FMT_RGB24,
                          FMT_YUYV, FMT_RGB444, FMT_RGB565, FMT_YUYV};

  initial begin
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // RGB24 straight out of reset: exercises the reset format, no write yet
    send_group(8'h00, 8'h00, 8'h00, 8'hA5, 1'b0);
    send_group(8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b1);
    send_group(8'h12, 8'h34, 8'h56, 8'hFF, 1'b0);

    // YUYV: all-zero drives red and blue negative, all-ones saturates red and blue high,
    // then black/white luma at neutral chroma, then two distinct lumas
    write_format(FMT_YUYV);
    send_group(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    send_group(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_group(8'd16, 8'd128, 8'd235, 8'd128, 1'b0);
    send_group(8'h51, 8'h5A, 8'hF0, 8'h3C, 1'b1);

    // RGB565: empty, full, then each channel alone; bytes 2 and 3 are junk
    write_format(FMT_RGB565);
    send_group(8'h00, 8'h00, 8'hFF, 8'hFF, 1'b0);
    send_group(8'hFF, 8'hFF, 8'h00, 8'h00, 1'b1);
    send_group(8'h00, 8'hF8, 8'h5A, 8'hA5, 1'b0);
    send_group(8'hE0, 8'h07, 8'hA5, 8'h5A, 1'b0);
    send_group(8'h1F, 8'h00, 8'hFF, 8'h00, 1'b1);

    // RGB444: the top nibble of byte 1 must be ignored
    write_format(FMT_RGB444);
    send_group(8'h00, 8'h00, 8'hFF, 8'hFF, 1'b0);
    send_group(8'hFF, 8'hFF, 8'h00, 8'h00, 1'b1);
    send_group(8'h00, 8'hF0, 8'h77, 8'h88, 1'b0);
    send_group(8'h00, 8'h0F, 8'h00, 8'h00, 1'b0);
    send_group(8'hF0, 8'h00, 8'h00, 8'h00, 1'b1);
    send_group(8'h0F, 8'h00, 8'h00, 8'h00, 1'b0);

    // Random phases across all formats; one phase runs with no idling at all
    foreach (phase_fmt[p]) begin
      write_format(phase_fmt[p]);
      calm = (p == 3);
      run_random(66);
      calm = 1'b0;
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/cpa_pkg.sv
src/cpa_out_stage.sv
src/camera_pixel_to_argb32.sv
src/cpa_checker.sv
test/tb_camera_pixel_to_argb32.sv
